/* sv/fcm_pkg.sv */
// Shared constants, command/status types and the Q8.24 to Q4.12 rounding
// function for the feature-wise linear modulation block.
// No dependencies.
`timescale 1ns / 1ps

package fcm_pkg;

   localparam int CHANNELS    = 16;
   localparam int CTRL_PARAMS = 8;

   localparam int DATA_W = 16;
   localparam int IDX_W  = 9;
   localparam int OP_W   = 2;

   // weight memory layout: gamma weights, gamma biases, beta weights, beta biases
   localparam int CP_WORDS     = CHANNELS * CTRL_PARAMS;
   localparam int GAMMA_B_BASE = CP_WORDS;
   localparam int BETA_W_BASE  = CP_WORDS + CHANNELS;
   localparam int BETA_B_BASE  = 2 * CP_WORDS + CHANNELS;
   localparam int WEIGHT_WORDS = 2 * CP_WORDS + 2 * CHANNELS;

   localparam int WADDR_W = $clog2(WEIGHT_WORDS);
   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int P_W     = (CTRL_PARAMS > 1) ? $clog2(CTRL_PARAMS) : 1;
   localparam int STEP_W  = $clog2(2 * CTRL_PARAMS + 2);

   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + $clog2(CTRL_PARAMS + 2) + 2;
   localparam int FRAC_W = 12;

   localparam logic signed [DATA_W-1:0] ONE_Q12 = DATA_W'(4096);

   localparam logic [OP_W-1:0] OP_LOAD_WEIGHT = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_PARAM   = 2'd1;
   localparam logic [OP_W-1:0] OP_RECOMPUTE   = 2'd2;
   localparam logic [OP_W-1:0] OP_APPLY       = 2'd3;

   typedef struct packed {
      logic               wt_wr;     // weight memory write
      logic               wt_zero;   // write zero (clearing sweep)
      logic [WADDR_W-1:0] wt_addr;
      logic               prm_wr;    // control parameter write
      logic               app_load;  // capture sample and its product
      logic               app_pass;  // channel out of range
      logic               app_emit;  // load output register
      logic               acc_clear;
      logic               rd_en;     // recompute weight read
      logic [WADDR_W-1:0] rd_addr;
      logic               rd_beta;
      logic               rd_bias;
      logic [P_W-1:0]     rd_psel;
      logic               rec_wr;    // store scale and offset
      logic [CH_W-1:0]    rec_chan;
   } fcm_cmd_type;

   typedef struct packed {
      logic out_free;
   } fcm_sts_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clip;
   } fcm_rs_type;

   // round half up by 2^12, then clip to the Q4.12 range
   function automatic fcm_rs_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0]        sum;
      logic signed [ACC_W-FRAC_W-1:0] q;
      fcm_rs_type                     r;
      sum = acc + ACC_W'(2048);
      q   = sum[ACC_W-1:FRAC_W];
      if (q > (ACC_W-FRAC_W)'(32767)) begin
         r.value = 16'h7fff;
         r.clip  = 1'b1;
      end else if (q < (ACC_W-FRAC_W)'(-32768)) begin
         r.value = 16'h8000;
         r.clip  = 1'b1;
      end else begin
         r.value = q[DATA_W-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

/* sv/fcm_ctrl.sv */
// Controller: clearing sweep after reset, word decode, recompute sequencing
// and apply handoff. Drives fcm_pkg::fcm_cmd_type to the datapath.
// Depends on fcm_pkg.
`timescale 1ns / 1ps

module fcm_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [fcm_pkg::OP_W-1:0]       req_op,
   input  logic [fcm_pkg::IDX_W-1:0]      req_index,
   output logic                           req_stall,
   input  fcm_pkg::fcm_sts_type           sts,
   output fcm_pkg::fcm_cmd_type           cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_APPLY  = 3'd2;
   localparam logic [2:0] ST_REC_RD = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_REC_WR = 3'd5;

   logic [2:0]                       state_ff, state_in;
   logic [fcm_pkg::WADDR_W-1:0]      clr_ff, clr_in;
   logic [fcm_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [fcm_pkg::CH_W-1:0]         chan_ff, chan_in;
   logic [fcm_pkg::WADDR_W-1:0]      row_ff, row_in;
   logic                             drain_ff, drain_in;
   logic                             accept;
   logic [fcm_pkg::STEP_W-1:0]       step_beta;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign step_beta = step_ff - fcm_pkg::STEP_W'(fcm_pkg::CTRL_PARAMS);

   always_comb begin
      // recompute address walk: gamma weights, beta weights, gamma bias, beta bias
      cmd.rd_beta = 1'b0;
      cmd.rd_bias = 1'b0;
      cmd.rd_psel = fcm_pkg::P_W'(step_ff);
      cmd.rd_addr = row_ff + fcm_pkg::WADDR_W'(step_ff);
      if (step_ff < fcm_pkg::STEP_W'(fcm_pkg::CTRL_PARAMS)) begin
         cmd.rd_addr = row_ff + fcm_pkg::WADDR_W'(step_ff);
      end else if (step_ff < fcm_pkg::STEP_W'(2 * fcm_pkg::CTRL_PARAMS)) begin
         cmd.rd_beta = 1'b1;
         cmd.rd_psel = fcm_pkg::P_W'(step_beta);
         cmd.rd_addr = fcm_pkg::WADDR_W'(fcm_pkg::BETA_W_BASE) + row_ff
                       + fcm_pkg::WADDR_W'(step_beta);
      end else if (step_ff == fcm_pkg::STEP_W'(2 * fcm_pkg::CTRL_PARAMS)) begin
         cmd.rd_bias = 1'b1;
         cmd.rd_addr = fcm_pkg::WADDR_W'(fcm_pkg::GAMMA_B_BASE)
                       + fcm_pkg::WADDR_W'(chan_ff);
      end else begin
         cmd.rd_beta = 1'b1;
         cmd.rd_bias = 1'b1;
         cmd.rd_addr = fcm_pkg::WADDR_W'(fcm_pkg::BETA_B_BASE)
                       + fcm_pkg::WADDR_W'(chan_ff);
      end

      state_in = state_ff;
      clr_in   = clr_ff;
      step_in  = step_ff;
      chan_in  = chan_ff;
      row_in   = row_ff;
      drain_in = drain_ff;

      cmd.wt_wr     = 1'b0;
      cmd.wt_zero   = 1'b0;
      cmd.wt_addr   = fcm_pkg::WADDR_W'(req_index);
      cmd.prm_wr    = 1'b0;
      cmd.app_load  = 1'b0;
      cmd.app_pass  = !(32'(req_index) < fcm_pkg::CHANNELS);
      cmd.app_emit  = 1'b0;
      cmd.acc_clear = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.rec_wr    = 1'b0;
      cmd.rec_chan  = chan_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wt_wr   = 1'b1;
            cmd.wt_zero = 1'b1;
            cmd.wt_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == fcm_pkg::WADDR_W'(fcm_pkg::WEIGHT_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  fcm_pkg::OP_LOAD_WEIGHT: begin
                     cmd.wt_wr = (32'(req_index) < fcm_pkg::WEIGHT_WORDS);
                  end
                  fcm_pkg::OP_SET_PARAM: begin
                     cmd.prm_wr = (32'(req_index) < fcm_pkg::CTRL_PARAMS);
                  end
                  fcm_pkg::OP_RECOMPUTE: begin
                     cmd.acc_clear = 1'b1;
                     step_in       = '0;
                     chan_in       = '0;
                     row_in        = '0;
                     state_in      = ST_REC_RD;
                  end
                  fcm_pkg::OP_APPLY: begin
                     cmd.app_load = 1'b1;
                     state_in     = ST_APPLY;
                  end
                  default: ;
               endcase
            end
         end
         ST_APPLY: begin
            if (sts.out_free) begin
               cmd.app_emit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REC_RD: begin
            cmd.rd_en = 1'b1;
            step_in   = step_ff + 1'b1;
            if (step_ff == fcm_pkg::STEP_W'(2 * fcm_pkg::CTRL_PARAMS + 1)) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // read and multiply stages still in flight
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_REC_WR;
            end
         end
         ST_REC_WR: begin
            cmd.rec_wr    = 1'b1;
            cmd.acc_clear = 1'b1;
            chan_in       = chan_ff + 1'b1;
            row_in        = row_ff + fcm_pkg::WADDR_W'(fcm_pkg::CTRL_PARAMS);
            step_in       = '0;
            if (chan_ff == fcm_pkg::CH_W'(fcm_pkg::CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_REC_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         step_ff  <= '0;
         chan_ff  <= '0;
         row_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         step_ff  <= step_in;
         chan_ff  <= chan_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

endmodule

/* sv/fcm_datapath.sv */
// Datapath: weight memory, parameter/scale/offset registers, recompute MAC
// pipeline, apply multiply and the output register.
// Depends on fcm_pkg; driven by fcm_ctrl commands.
`timescale 1ns / 1ps

module fcm_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fcm_pkg::fcm_cmd_type                  cmd,
   output fcm_pkg::fcm_sts_type                  sts,
   input  logic [fcm_pkg::IDX_W-1:0]             req_index,
   input  logic signed [fcm_pkg::DATA_W-1:0]     req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fcm_pkg::DATA_W-1:0]     rsp_result_value,
   output logic                                  rsp_saturated
);

   logic signed [fcm_pkg::DATA_W-1:0] wmem [fcm_pkg::WEIGHT_WORDS];
   logic signed [fcm_pkg::DATA_W-1:0] rd_data_ff;

   logic signed [fcm_pkg::DATA_W-1:0] param_ff  [fcm_pkg::CTRL_PARAMS];
   logic signed [fcm_pkg::DATA_W-1:0] scale_ff  [fcm_pkg::CHANNELS];
   logic signed [fcm_pkg::DATA_W-1:0] offset_ff [fcm_pkg::CHANNELS];

   // recompute pipeline: read -> multiply -> accumulate
   logic                              t1_valid_ff, t1_beta_ff, t1_bias_ff;
   logic [fcm_pkg::P_W-1:0]           t1_psel_ff;
   logic                              t2_valid_ff, t2_beta_ff;
   logic signed [fcm_pkg::DATA_W-1:0] mul_b;
   logic signed [fcm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [fcm_pkg::ACC_W-1:0]  g_acc_ff, b_acc_ff;
   fcm_pkg::fcm_rs_type               g_rs, b_rs;

   // apply
   logic [fcm_pkg::CH_W-1:0]          app_idx;
   logic signed [fcm_pkg::DATA_W-1:0] app_val_ff;
   logic                              app_pass_ff;
   logic signed [fcm_pkg::PROD_W-1:0] app_prod_ff;
   logic signed [fcm_pkg::DATA_W-1:0] app_ofs_ff;
   logic signed [fcm_pkg::ACC_W-1:0]  app_acc;
   fcm_pkg::fcm_rs_type               app_rs;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [fcm_pkg::DATA_W-1:0] rsp_value_ff;
   logic                              rsp_sat_ff;

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.wt_wr) begin
         wmem[cmd.wt_addr] <= cmd.wt_zero ? '0 : req_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= wmem[cmd.rd_addr];
      end
   end

   assign mul_b   = t1_bias_ff ? fcm_pkg::ONE_Q12 : param_ff[t1_psel_ff];
   assign prod_in = fcm_pkg::PROD_W'(rd_data_ff) * fcm_pkg::PROD_W'(mul_b);
   assign g_rs    = fcm_pkg::round_sat(g_acc_ff);
   assign b_rs    = fcm_pkg::round_sat(b_acc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
      end else begin
         t1_valid_ff <= cmd.rd_en;
         t2_valid_ff <= t1_valid_ff;
      end
      t1_beta_ff <= cmd.rd_beta;
      t1_bias_ff <= cmd.rd_bias;
      t1_psel_ff <= cmd.rd_psel;
      t2_beta_ff <= t1_beta_ff;
      prod_ff    <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         // scale starts at 1.0 in Q8.24
         g_acc_ff <= fcm_pkg::ACC_W'(4096 * 4096);
         b_acc_ff <= '0;
      end else if (t2_valid_ff) begin
         if (t2_beta_ff) begin
            b_acc_ff <= b_acc_ff + fcm_pkg::ACC_W'(prod_ff);
         end else begin
            g_acc_ff <= g_acc_ff + fcm_pkg::ACC_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < fcm_pkg::CTRL_PARAMS; p++) begin
            param_ff[p] <= '0;
         end
         for (int c = 0; c < fcm_pkg::CHANNELS; c++) begin
            scale_ff[c]  <= fcm_pkg::ONE_Q12;
            offset_ff[c] <= '0;
         end
      end else begin
         if (cmd.prm_wr) begin
            param_ff[req_index[fcm_pkg::P_W-1:0]] <= req_value;
         end
         if (cmd.rec_wr) begin
            scale_ff[cmd.rec_chan]  <= g_rs.value;
            offset_ff[cmd.rec_chan] <= b_rs.value;
         end
      end
   end

   assign app_idx = req_index[fcm_pkg::CH_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.app_load) begin
         app_val_ff  <= req_value;
         app_pass_ff <= cmd.app_pass;
         app_prod_ff <= fcm_pkg::PROD_W'(req_value)
                        * fcm_pkg::PROD_W'(scale_ff[app_idx]);
         app_ofs_ff  <= offset_ff[app_idx];
      end
   end

   assign app_acc = fcm_pkg::ACC_W'(app_prod_ff)
                    + (fcm_pkg::ACC_W'(app_ofs_ff) <<< fcm_pkg::FRAC_W);
   assign app_rs  = fcm_pkg::round_sat(app_acc);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.app_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.app_emit) begin
         rsp_value_ff <= app_pass_ff ? app_val_ff : app_rs.value;
         rsp_sat_ff   <= app_pass_ff ? 1'b0 : app_rs.clip;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

/* sv/film_channel_modulator.sv */
// Feature-wise linear modulation in Q4.12 (top level).
// Request word: op, index, value. Op 0 loads a weight word, op 1 sets a
// control parameter, op 2 rebuilds every channel's scale and offset, op 3
// modulates one sample and returns one response word (result, saturated).
// Ops 0 to 2 return nothing.
// Timing: ops 0 and 1 are written on the accepting edge. An apply is accepted
// and its product registered; the response is then loaded into the output
// register once that register is free, and rsp_valid rises as it is loaded.
// No new request is accepted until then.
// A recompute walks the weight memory through one read port and one shared
// multiplier, channel by channel (reads, drain, scale and offset write),
// during which req_stall is high.
// Reset: synchronous, active high. The weight memory is then cleared one
// word a cycle with req_stall high; scales come up as 1.0,
// offsets and parameters as 0.
// A stalled response holds in the output register; an apply waiting behind
// it holds req_stall high until the register frees up.
// Depends on fcm_pkg, fcm_ctrl, fcm_datapath.
`timescale 1ns / 1ps

module film_channel_modulator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fcm_pkg::OP_W-1:0]              req_op,
   input  logic [fcm_pkg::IDX_W-1:0]             req_index,
   input  logic signed [fcm_pkg::DATA_W-1:0]     req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fcm_pkg::DATA_W-1:0]     rsp_result_value,
   output logic                                  rsp_saturated
);

   fcm_pkg::fcm_cmd_type cmd;
   fcm_pkg::fcm_sts_type sts;

   fcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_index (req_index),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fcm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_index        (req_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

/* tb/sv/film_channel_modulator_tb.sv */
// Self-checking testbench for film_channel_modulator: weight loads, parameter
// writes, recomputes and sample applies against an in-bench Q4.12 predictor.
// Depends on fcm_pkg and film_channel_modulator.
`timescale 1ns / 1ps

module film_channel_modulator_tb;

   typedef struct {
      shortint value;
      bit      sat;
   } mod_word_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [fcm_pkg::OP_W-1:0]          req_op = fcm_pkg::OP_LOAD_WEIGHT;
   logic [fcm_pkg::IDX_W-1:0]         req_index = '0;
   logic signed [fcm_pkg::DATA_W-1:0] req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [fcm_pkg::DATA_W-1:0] rsp_result_value;
   logic                              rsp_saturated;

   // predictor state
   shortint      weights [fcm_pkg::WEIGHT_WORDS];
   shortint      params [fcm_pkg::CTRL_PARAMS];
   shortint      scales [fcm_pkg::CHANNELS];
   shortint      offsets [fcm_pkg::CHANNELS];
   mod_word_type modulated_q[$];

   int   errors = 0;
   int   gap_max = 0;
   int   burst_left = 0;
   int   stall_pct = 0;
   logic holding = 1'b0;
   event hold_start;

   film_channel_modulator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_index        (req_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_saturated    (rsp_saturated)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("film_channel_modulator_tb NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (errors < 40)
         $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Q8.24 -> Q4.12, round half up, clip
   function automatic shortint q12_round_clip(input longint acc, output bit clip);
      longint r;
      r = (acc + 2048) >>> 12;
      clip = 1'b0;
      if (r > 32767) begin
         r = 32767;
         clip = 1'b1;
      end else if (r < -32768) begin
         r = -32768;
         clip = 1'b1;
      end
      return shortint'(r);
   endfunction

   function automatic void rebuild_modulation();
      longint g;
      longint b;
      bit     clip;
      for (int c = 0; c < fcm_pkg::CHANNELS; c++) begin
         g = longint'(4096) * 4096
             + longint'(weights[fcm_pkg::GAMMA_B_BASE + c]) * 4096;
         b = longint'(weights[fcm_pkg::BETA_B_BASE + c]) * 4096;
         for (int p = 0; p < fcm_pkg::CTRL_PARAMS; p++) begin
            g += longint'(weights[c * fcm_pkg::CTRL_PARAMS + p]) * params[p];
            b += longint'(weights[fcm_pkg::BETA_W_BASE + c * fcm_pkg::CTRL_PARAMS + p])
                 * params[p];
         end
         scales[c]  = q12_round_clip(g, clip);
         offsets[c] = q12_round_clip(b, clip);
      end
   endfunction

   function automatic void modulate_predict(input logic [fcm_pkg::OP_W-1:0] op,
                                            input int idx, input shortint val);
      mod_word_type w;
      longint       acc;
      bit           clip;
      case (op)
         fcm_pkg::OP_LOAD_WEIGHT: if (idx < fcm_pkg::WEIGHT_WORDS) weights[idx] = val;
         fcm_pkg::OP_SET_PARAM:   if (idx < fcm_pkg::CTRL_PARAMS) params[idx] = val;
         fcm_pkg::OP_RECOMPUTE:   rebuild_modulation();
         fcm_pkg::OP_APPLY: begin
            if (idx >= fcm_pkg::CHANNELS) begin
               w.value = val;
               w.sat   = 1'b0;
            end else begin
               acc = longint'(val) * scales[idx] + longint'(offsets[idx]) * 4096;
               w.value = q12_round_clip(acc, clip);
               w.sat   = clip;
            end
            modulated_q.insert(modulated_q.size(), w);
         end
      endcase
   endfunction

   // one request word; bursts of random length separated by random gaps
   task automatic send_word(input logic [fcm_pkg::OP_W-1:0] op, input int idx,
                            input shortint val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op    <= op;
      req_index <= fcm_pkg::IDX_W'(idx);
      req_value <= val;
      do @(posedge clock); while (req_stall !== 1'b0);
      modulate_predict(op, idx, val);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (modulated_q.size() != 0);
   endtask

   function automatic shortint rand_sample();
      case ($urandom_range(0, 5))
         0:       return 32767;
         1:       return -32768;
         2, 3:    return shortint'(int'($urandom_range(0, 8191)) - 4096);
         default: return shortint'($urandom());
      endcase
   endfunction

   // mostly small weights so scales do not all pin at the rails
   function automatic shortint rand_weight();
      case ($urandom_range(0, 7))
         0:       return shortint'($urandom());
         1:       return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
         default: return shortint'(int'($urandom_range(0, 2048)) - 1024);
      endcase
   endfunction

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      mod_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (modulated_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %0d sat %0b",
                                      rsp_result_value, rsp_saturated));
         end else begin
            want = modulated_q.pop_front();
            if (rsp_result_value !== want.value)
               report_mismatch($sformatf("result %0d, want %0d",
                                         rsp_result_value, want.value));
            if (rsp_saturated !== want.sat)
               report_mismatch($sformatf("saturated %b, want %0b (result %0d)",
                                         rsp_saturated, want.sat, want.value));
         end
      end
      if (holding)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // long receiver hold-off
   always begin
      @(hold_start);
      holding <= 1'b1;
      repeat (400) @(posedge clock);
      holding <= 1'b0;
   end

   // after reset every channel is identity
   task automatic test_reset_state();
      gap_max = 0;
      send_word(fcm_pkg::OP_APPLY, 0, 32767);
      send_word(fcm_pkg::OP_APPLY, fcm_pkg::CHANNELS - 1, -32768);
      send_word(fcm_pkg::OP_APPLY, 7, 0);
      send_word(fcm_pkg::OP_APPLY, fcm_pkg::CHANNELS, 1234);
      send_word(fcm_pkg::OP_APPLY, 511, -1);
      wait_drain();
   endtask

   task automatic test_edge_cases();
      gap_max = 2;
      stall_pct <= 30;
      send_word(fcm_pkg::OP_LOAD_WEIGHT, 0, 4096);
      send_word(fcm_pkg::OP_LOAD_WEIGHT, fcm_pkg::WEIGHT_WORDS - 1, -32768);
      send_word(fcm_pkg::OP_LOAD_WEIGHT, fcm_pkg::WEIGHT_WORDS, 7);  // past the end, dropped
      send_word(fcm_pkg::OP_LOAD_WEIGHT, 511, -1);
      send_word(fcm_pkg::OP_LOAD_WEIGHT, fcm_pkg::GAMMA_B_BASE + 1, 32767);  // scale clips
      send_word(fcm_pkg::OP_LOAD_WEIGHT, fcm_pkg::GAMMA_B_BASE + 3, -2048);  // scale 0.5
      send_word(fcm_pkg::OP_LOAD_WEIGHT,
                fcm_pkg::BETA_W_BASE + 3 * fcm_pkg::CTRL_PARAMS - 1, -32768);
      send_word(fcm_pkg::OP_SET_PARAM, 0, 8192);
      send_word(fcm_pkg::OP_SET_PARAM, fcm_pkg::CTRL_PARAMS - 1, 32767);
      send_word(fcm_pkg::OP_SET_PARAM, fcm_pkg::CTRL_PARAMS, 5);  // dropped
      send_word(fcm_pkg::OP_SET_PARAM, 511, -32768);
      send_word(fcm_pkg::OP_RECOMPUTE, 511, -1);
      send_word(fcm_pkg::OP_APPLY, 0, 4096);
      send_word(fcm_pkg::OP_APPLY, 1, 32767);
      send_word(fcm_pkg::OP_APPLY, 1, -32768);
      send_word(fcm_pkg::OP_APPLY, 2, 0);
      send_word(fcm_pkg::OP_APPLY, 2, 4096);
      send_word(fcm_pkg::OP_APPLY, 3, 1);
      send_word(fcm_pkg::OP_APPLY, 3, -1);
      send_word(fcm_pkg::OP_APPLY, fcm_pkg::CHANNELS - 1, -32768);
      send_word(fcm_pkg::OP_APPLY, 300, 32767);
      wait_drain();
   endtask

   // receiver holds off while the sender keeps pushing applies
   task automatic test_backpressure();
      gap_max = 0;
      stall_pct <= 0;
      -> hold_start;
      repeat (40)
         send_word(fcm_pkg::OP_APPLY, $urandom_range(0, fcm_pkg::CHANNELS - 1),
                   rand_sample());
      wait_drain();
   endtask

   // programs: load weights, set params, recompute, then a run of applies
   task automatic test_random_programs();
      int sent;
      sent = 0;
      while (sent < 1700) begin
         case ($urandom_range(0, 3))
            0: begin gap_max = 0;  stall_pct <= 0;  end
            1: begin gap_max = 3;  stall_pct <= 20; end
            2: begin gap_max = 10; stall_pct <= 50; end
            default: begin gap_max = 0; stall_pct <= 80; end
         endcase
         repeat ($urandom_range(2, 20)) begin
            if ($urandom_range(0, 9) == 0) begin
               send_word(fcm_pkg::OP_LOAD_WEIGHT,
                         $urandom_range(fcm_pkg::WEIGHT_WORDS, 511), rand_weight());
            end else begin
               send_word(fcm_pkg::OP_LOAD_WEIGHT,
                         $urandom_range(0, fcm_pkg::WEIGHT_WORDS - 1), rand_weight());
               sent++;
            end
         end
         repeat ($urandom_range(0, fcm_pkg::CTRL_PARAMS)) begin
            if ($urandom_range(0, 7) == 0) begin
               send_word(fcm_pkg::OP_SET_PARAM,
                         $urandom_range(fcm_pkg::CTRL_PARAMS, 511), rand_sample());
            end else begin
               send_word(fcm_pkg::OP_SET_PARAM,
                         $urandom_range(0, fcm_pkg::CTRL_PARAMS - 1), rand_sample());
               sent++;
            end
         end
         // now and then apply with stale scales
         if ($urandom_range(0, 7) != 0) begin
            send_word(fcm_pkg::OP_RECOMPUTE, $urandom_range(0, 511),
                      shortint'($urandom()));
            sent++;
         end
         repeat ($urandom_range(10, 80)) begin
            case ($urandom_range(0, 19))
               0: begin
                  send_word(fcm_pkg::OP_APPLY, $urandom_range(fcm_pkg::CHANNELS, 511),
                            rand_sample());
                  sent++;
               end
               1: send_word(fcm_pkg::OP_W'($urandom_range(0, 1)), $urandom_range(0, 511),
                            shortint'($urandom()));
               default: begin
                  send_word(fcm_pkg::OP_APPLY,
                            $urandom_range(0, fcm_pkg::CHANNELS - 1), rand_sample());
                  sent++;
               end
            endcase
         end
      end
      gap_max = 0;
      wait_drain();
   endtask

   initial begin
      foreach (weights[i]) weights[i] = 0;
      foreach (params[i]) params[i] = 0;
      foreach (scales[i]) scales[i] = 4096;
      foreach (offsets[i]) offsets[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_edge_cases();
      test_backpressure();
      test_random_programs();
      stall_pct <= 0;
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("film_channel_modulator_tb OK");
      else
         $display("film_channel_modulator_tb NOT OK");
      $finish;
   end

endmodule
